/* sv/tss_pkg.sv */
// tss_pkg: shared types, codes and defaults for the two-stack shared store.
// No dependencies; imported by every module of the block.
`default_nettype none
package tss_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned WORD_W       = 32;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PUSH = 2'd0;
	localparam kind_t KIND_POP  = 2'd1;
	localparam kind_t KIND_PEEK = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	localparam logic SEL_LOWER = 1'b0;

endpackage
`default_nettype wire

/* sv/two_stacks_shared_store.sv */
// two_stacks_shared_store: top level; stack pointers, operation decode, result register.
// Depends on tss_pkg and tss_ram.
//
//  channel   handshake              payload
//  item in   start (busy low)       kind, stack_sel, push_value
//  result    done (one cycle)       read_word, status
//
// The result of an item taken at one edge is shown, with done high, in the following
// cycle. One item per cycle is taken; busy stays low, since a
// push writes the store at its own accept edge and the store read port is free every
// cycle. Reset sets both stack pointers to empty (lower to zero, upper to CAPACITY); store contents are
// left as they are. The receiver cannot stall, so no result is ever held.
`default_nettype none
module two_stacks_shared_store
	import tss_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               kind,
	input  wire logic                     stack_sel,
	input  wire logic signed [WORD_W-1:0] push_value,
	output logic                          done,
	output logic signed [WORD_W-1:0]      read_word,
	output logic [1:0]                    status
);

	localparam int unsigned PW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);

	logic [PW-1:0] lower_q, upper_q;
	logic [PW-1:0] lower_d, upper_d;
	logic          accept;
	logic          full, empty;
	logic          we, re;
	logic [PW-1:0] wptr, rptr;
	status_t       status_d;

	logic          done_s1;
	logic          hit_s1;
	status_t       status_s1;
	logic [WORD_W-1:0] rdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = lower_q >= upper_q;
	assign empty  = (stack_sel == SEL_LOWER) ? (lower_q == '0) : (upper_q == PW'(CAPACITY));

	always_comb begin
		lower_d  = lower_q;
		upper_d  = upper_q;
		we       = 1'b0;
		re       = 1'b0;
		wptr     = lower_q;
		rptr     = upper_q;
		status_d = ST_OK;
		case (kind)
			KIND_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (stack_sel == SEL_LOWER) begin
					we      = accept;
					wptr    = lower_q;
					lower_d = lower_q + PW'(1);
				end else begin
					we      = accept;
					wptr    = upper_q - PW'(1);
					upper_d = upper_q - PW'(1);
				end
			end
			KIND_POP, KIND_PEEK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					re = accept;
					if (stack_sel == SEL_LOWER) begin
						rptr = lower_q - PW'(1);
						if (kind == KIND_POP) begin
							lower_d = lower_q - PW'(1);
						end
					end else begin
						rptr = upper_q;
						if (kind == KIND_POP) begin
							upper_d = upper_q + PW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q   <= '0;
			upper_q   <= PW'(CAPACITY);
			done_s1   <= 1'b0;
			hit_s1    <= 1'b0;
			status_s1 <= ST_OK;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				lower_q   <= lower_d;
				upper_q   <= upper_d;
				hit_s1    <= re;
				status_s1 <= status_d;
			end
		end
	end

	tss_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wptr[AW-1:0]),
		.wdata(push_value),
		.re   (re),
		.raddr(rptr[AW-1:0]),
		.rdata(rdata)
	);

	assign done      = done_s1;
	assign read_word = hit_s1 ? $signed(rdata) : '0;
	assign status    = status_s1;

endmodule
`default_nettype wire

/* sv/tss_ram.sv */
// tss_ram: single-port-write, single-port-read store with registered read data.
// Depends on tss_pkg for the word width.
`default_nettype none
module tss_ram
	import tss_pkg::*;
#(
	parameter int unsigned DEPTH = CAPACITY_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/tss_checker.sv */
// tss_checker: port-level checks on the two-stack shared store, bound to the top level.
// Depends on tss_pkg and two_stacks_shared_store.
`default_nettype none
module tss_checker
	import tss_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic [1:0]               kind,
	input wire logic                     done,
	input wire logic signed [WORD_W-1:0] read_word,
	input wire logic [1:0]               status
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("item taken without a result in the next cycle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an item");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_word == '0))
		else $error("data returned with a failing status");

	a_full_is_push: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> ($past(kind) == KIND_PUSH))
		else $error("full status on an item that is not a push");

	a_empty_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |->
			($past(kind) == KIND_POP || $past(kind) == KIND_PEEK))
		else $error("empty status on an item that is not a pop or peek");

endmodule

bind two_stacks_shared_store tss_checker u_tss_checker (.*);
`default_nettype wire

/* bench/two_stacks_shared_store_tb.sv */
// Testbench for two_stacks_shared_store: a directed table, then random bursts of push, pop
// and peek, each result checked against the table or a local model of the two stacks. Needs tss_pkg
// and the block itself; reads no files.
`timescale 1ns / 1ps
module two_stacks_shared_store_tb;
	import tss_pkg::*;

	localparam int unsigned DEPTH      = CAPACITY_DEF;
	localparam kind_t       KIND_SPARE = 2'd3;
	localparam logic        SEL_UPPER  = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		status_t           st;
	} outcome_t;

	typedef struct {
		kind_t             k;
		logic              s;
		logic [WORD_W-1:0] v;
		int                reps;
		bit                typed;
		outcome_t          res;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	kind_t                    kind;
	logic                     stack_sel;
	logic signed [WORD_W-1:0] push_value;
	logic                     done;
	logic signed [WORD_W-1:0] read_word;
	logic [1:0]               status;

	logic [WORD_W-1:0] mem_words [DEPTH];
	int unsigned       lower_n;
	int unsigned       upper_top;
	outcome_t          pending_results [$];
	plan_row_t         plan [$];

	int n_items, n_checked, n_errors;
	int n_ok, n_full, n_empty, n_spare;

	two_stacks_shared_store #(
		.CAPACITY(DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.stack_sel (stack_sel),
		.push_value(push_value),
		.done      (done),
		.read_word (read_word),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("two_stacks_shared_store_tb failed");
		$finish;
	end

	function automatic outcome_t stacks_step(kind_t k, logic s, logic [WORD_W-1:0] v);
		outcome_t r;
		r.word = '0;
		r.st   = ST_OK;
		case (k)
			KIND_PUSH: begin
				if (lower_n >= upper_top) begin
					r.st = ST_FULL;
				end else if (s == SEL_LOWER) begin
					mem_words[lower_n] = v;
					lower_n++;
				end else begin
					upper_top--;
					mem_words[upper_top] = v;
				end
			end
			KIND_POP, KIND_PEEK: begin
				if (s == SEL_LOWER) begin
					if (lower_n == 0) begin
						r.st = ST_EMPTY;
					end else begin
						r.word = mem_words[lower_n - 1];
						if (k == KIND_POP) lower_n--;
					end
				end else begin
					if (upper_top >= DEPTH) begin
						r.st = ST_EMPTY;
					end else begin
						r.word = mem_words[upper_top];
						if (k == KIND_POP) upper_top++;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic plan_op(input kind_t k, input logic s, input logic [WORD_W-1:0] v,
			input int reps, input bit typed, input logic [WORD_W-1:0] w, input status_t st);
		plan_row_t row;
		row.k     = k;
		row.s     = s;
		row.v     = v;
		row.reps  = reps;
		row.typed = typed;
		row.res   = '{word: w, st: st};
		plan.push_back(row);
	endtask

	// drive at the falling edge, take the item at the first rising edge with busy low
	task automatic issue_op(input kind_t k, input logic s, input logic [WORD_W-1:0] v,
			input bit typed, input outcome_t res);
		outcome_t pred;
		@(negedge clk);
		start      <= 1'b1;
		kind       <= k;
		stack_sel  <= s;
		push_value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		pred = stacks_step(k, s, v);
		if (typed) pred = res;
		pending_results.push_back(pred);
		n_items++;
		if (k == KIND_SPARE) n_spare++;
		else if (pred.st == ST_FULL) n_full++;
		else if (pred.st == ST_EMPTY) n_empty++;
		else n_ok++;
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained;
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		outcome_t exp_res;
		if (arst_n && done !== 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none pending: read_word %h status %0d",
					$time, read_word, status);
				n_errors++;
			end else begin
				exp_res = pending_results.pop_front();
				n_checked++;
				if (read_word !== exp_res.word) begin
					$display("%0t: read_word expected %h got %h", $time, exp_res.word,
						read_word);
					n_errors++;
				end
				if (status !== exp_res.st) begin
					$display("%0t: status expected %0d got %0d", $time, exp_res.st, status);
					n_errors++;
				end
			end
		end
	end

	initial begin
		int        mode, len, bias, r, push_pct, gap;
		bit        quiet;
		kind_t     k;
		logic      s;
		logic [WORD_W-1:0] v;
		outcome_t  none;

		none       = '{word: '0, st: ST_OK};
		arst_n     = 1'b0;
		start      = 1'b0;
		kind       = KIND_PUSH;
		stack_sel  = SEL_LOWER;
		push_value = '0;
		lower_n    = 0;
		upper_top  = DEPTH;
		n_items = 0; n_checked = 0; n_errors = 0;
		n_ok = 0; n_full = 0; n_empty = 0; n_spare = 0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// empty after reset, spare kind, extremes, then fill to the brim, push when full and pop back
		plan_op(KIND_POP,   SEL_LOWER, 32'h0,        1, 1, 32'h0,        ST_EMPTY);
		plan_op(KIND_PEEK,  SEL_UPPER, 32'h0,        1, 1, 32'h0,        ST_EMPTY);
		plan_op(KIND_POP,   SEL_UPPER, 32'hFFFFFFFF, 1, 1, 32'h0,        ST_EMPTY);
		plan_op(KIND_PEEK,  SEL_LOWER, 32'h0,        1, 1, 32'h0,        ST_EMPTY);
		plan_op(KIND_SPARE, SEL_UPPER, 32'hFFFFFFFF, 1, 1, 32'h0,        ST_OK);
		plan_op(KIND_PUSH,  SEL_LOWER, 32'h7FFFFFFF, 1, 1, 32'h0,        ST_OK);
		plan_op(KIND_PUSH,  SEL_UPPER, 32'h80000000, 1, 1, 32'h0,        ST_OK);
		plan_op(KIND_PEEK,  SEL_LOWER, 32'h0,        1, 1, 32'h7FFFFFFF, ST_OK);
		plan_op(KIND_PEEK,  SEL_UPPER, 32'h0,        1, 1, 32'h80000000, ST_OK);
		plan_op(KIND_POP,   SEL_LOWER, 32'h0,        1, 1, 32'h7FFFFFFF, ST_OK);
		plan_op(KIND_POP,   SEL_LOWER, 32'h0,        1, 1, 32'h0,        ST_EMPTY);
		plan_op(KIND_PUSH,  SEL_LOWER, 32'hFFFFFFFF, 8, 1, 32'h0,        ST_OK);
		plan_op(KIND_PUSH,  SEL_UPPER, 32'h0,        7, 1, 32'h0,        ST_OK);
		plan_op(KIND_PUSH,  SEL_UPPER, 32'h5A5A5A5A, 1, 1, 32'h0,        ST_FULL);
		plan_op(KIND_PUSH,  SEL_LOWER, 32'h5A5A5A5A, 1, 1, 32'h0,        ST_FULL);
		plan_op(KIND_POP,   SEL_UPPER, 32'h0,        1, 1, 32'h0,        ST_OK);
		plan_op(KIND_PUSH,  SEL_UPPER, 32'hA5A5A5A5, 1, 1, 32'h0,        ST_OK);
		plan_op(KIND_PEEK,  SEL_UPPER, 32'h0,        1, 1, 32'hA5A5A5A5, ST_OK);
		plan_op(KIND_PUSH,  SEL_LOWER, 32'h1,        1, 1, 32'h0,        ST_FULL);
		plan_op(KIND_POP,   SEL_UPPER, 32'h0,        9, 0, 32'h0,        ST_OK);
		plan_op(KIND_PEEK,  SEL_LOWER, 32'h0,        1, 1, 32'hFFFFFFFF, ST_OK);
		plan_op(KIND_POP,   SEL_LOWER, 32'h0,        4, 0, 32'h0,        ST_OK);

		foreach (plan[i])
			repeat (plan[i].reps) issue_op(plan[i].k, plan[i].s, plan[i].v, plan[i].typed,
				plan[i].res);
		wait_drained();

		// random bursts: filling, draining or mixed, some biased to one stack
		mode = 0;
		while (n_items < 540) begin
			len   = $urandom_range(4, 24);
			bias  = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 3) == 0);
			case (mode)
				0:       push_pct = 75;
				1:       push_pct = 20;
				default: push_pct = 45;
			endcase
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 3) k = KIND_SPARE;
				else if (r < 3 + push_pct) k = KIND_PUSH;
				else k = ($urandom_range(0, 2) == 0) ? KIND_PEEK : KIND_POP;
				if (bias == 2 || $urandom_range(0, 4) == 0) s = $urandom_range(0, 1);
				else s = bias[0];
				case ($urandom_range(0, 9))
					0:       v = 32'h0;
					1:       v = 32'hFFFFFFFF;
					2:       v = 32'h7FFFFFFF;
					3:       v = 32'h80000000;
					default: v = $urandom;
				endcase
				issue_op(k, s, v, 1'b0, none);
				if (!quiet) begin
					r = $urandom_range(0, 99);
					if (r < 60) gap = 0;
					else if (r < 90) gap = $urandom_range(1, 3);
					else gap = $urandom_range(5, 30);
					idle_for(gap);
				end
			end
			if ($urandom_range(0, 5) == 0) wait_drained();
			mode = $urandom_range(0, 2);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			n_errors++;
		end
		$display("%0d items, %0d results checked: %0d ok, %0d full, %0d empty, %0d spare kind",
			n_items, n_checked, n_ok, n_full, n_empty, n_spare);
		if (n_errors == 0) begin
			$display("two_stacks_shared_store_tb passed");
		end else begin
			$display("two_stacks_shared_store_tb failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/tss_pkg.sv
sv/tss_ram.sv
sv/two_stacks_shared_store.sv
sv/tss_checker.sv
bench/two_stacks_shared_store_tb.sv
